### rtl/scale_indicator_frame_parser_defines.svh
// Assertion macros for the weighing indicator frame parser.
// Included by the files that check their own logic; needs no other file.
// The checking forms are compiled out when SYNTHESIS is defined.
`ifndef SCALE_INDICATOR_FRAME_PARSER_DEFINES_SVH
`define SCALE_INDICATOR_FRAME_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define SIFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// property checked on every clock edge, reset included
`define SIFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SIFP_ASSERT(lbl, prop, msg)
`define SIFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/sifp_pkg.sv
// Shared types and constants of the weighing indicator frame parser.
// Used by the front classifier, the word queue, the back end and the top level.
`timescale 1ns / 1ps

package sifp_pkg;

   // framing characters
   localparam logic [7:0] STX_CHAR   = 8'h02;
   localparam logic [7:0] ETX_CHAR   = 8'h03;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] SOH_CHAR   = 8'h01;
   localparam logic [7:0] MINUS_CHAR = 8'h2D;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] ZERO_CHAR  = 8'h30;
   localparam logic [7:0] NINE_CHAR  = 8'h39;

   // frame formats
   localparam logic [1:0] FMT_STATUS  = 2'd0;
   localparam logic [1:0] FMT_DECIMAL = 2'd1;
   localparam logic [1:0] FMT_SEVEN   = 2'd2;

   // terminator position of each format
   localparam int POS_WIDTH = 5;
   localparam logic [POS_WIDTH-1:0] LAST_STATUS  = 5'd16;
   localparam logic [POS_WIDTH-1:0] LAST_DECIMAL = 5'd11;
   localparam logic [POS_WIDTH-1:0] LAST_SEVEN   = 5'd9;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_TERM = 2'd1;
   localparam logic [1:0] ST_NONDIGIT = 2'd2;

   // register map
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic CSR_IDX_FORMAT = 1'b0;

   localparam int WEIGHT_WIDTH = 24;
   localparam int TARE_WIDTH   = 20;
   localparam int EXP_WIDTH    = 5;

   // what the back end does with one classified word
   typedef enum logic [2:0] {
      OP_START,
      OP_CODE,
      OP_SIGN_B,
      OP_WEIGHT,
      OP_TARE,
      OP_SIGN,
      OP_DECIMAL,
      OP_TERM
   } op_type;

   // classified word passed from front to back
   typedef struct packed {
      op_type     op;
      logic [1:0] fmt;    // format in force for this byte
      logic [3:0] digit;  // digit value, zero for a non-digit
      logic       bad;    // non-digit in a numeric field
      logic       flag;   // minus sign, status-B bit 1 or bad terminator
      logic       aux;    // sign byte was SOH
      logic [2:0] low3;   // status-A low bits
   } entry_type;

   // queue status seen by the top level
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

endpackage

### rtl/sifp_front.sv
// Front end: tracks frame position and classifies each received byte.
// Depends on sifp_pkg; pushes classified words into sifp_queue.
`timescale 1ns / 1ps

module sifp_front
   import sifp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] frame_format,
   input  logic       byte_take,
   input  logic [7:0] rx_byte,
   output logic       push,
   output entry_type  push_word
);

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [1:0]           fmt;
   logic [POS_WIDTH-1:0] last;
   logic                 is_digit;
   logic                 is_space;
   entry_type            word;
   logic                 word_used;

   // unused selector falls back to the status format
   always_comb begin
      fmt = (frame_format == 2'd3) ? FMT_STATUS : frame_format;
      case (fmt)
         FMT_DECIMAL: last = LAST_DECIMAL;
         FMT_SEVEN:   last = LAST_SEVEN;
         default:     last = LAST_STATUS;
      endcase
   end

   assign is_digit = (rx_byte >= ZERO_CHAR) && (rx_byte <= NINE_CHAR);
   assign is_space = (rx_byte == SPACE_CHAR);

   // classify the byte at the current position
   always_comb begin
      word       = '0;
      word.op    = OP_START;
      word.fmt   = fmt;
      word.digit = is_digit ? rx_byte[3:0] : 4'd0;
      word.low3  = rx_byte[2:0];
      word.aux   = (rx_byte == SOH_CHAR);
      word_used  = 1'b0;
      pos_in     = pos_ff;
      if (pos_ff == '0) begin
         if (rx_byte == STX_CHAR) begin
            word_used = 1'b1;
            pos_in    = 5'd1;
         end
      end else if (pos_ff >= last) begin
         word.op   = OP_TERM;
         word.flag = (fmt == FMT_DECIMAL) ? (rx_byte != ETX_CHAR) : (rx_byte != CR_CHAR);
         word_used = 1'b1;
         pos_in    = '0;
      end else begin
         pos_in = pos_ff + 5'd1;
         case (fmt)
            FMT_DECIMAL: begin
               if (pos_ff == 5'd1) begin
                  word.op   = OP_SIGN;
                  word.flag = (rx_byte == MINUS_CHAR);
                  word_used = 1'b1;
               end else if (pos_ff <= 5'd7) begin
                  word.op   = OP_WEIGHT;
                  word.bad  = !is_digit;
                  word_used = 1'b1;
               end else if (pos_ff == 5'd8) begin
                  word.op   = OP_DECIMAL;
                  word.bad  = !is_digit;
                  word_used = 1'b1;
               end
            end
            FMT_SEVEN: begin
               if (pos_ff == 5'd1) begin
                  word.op   = OP_SIGN;
                  word.flag = (rx_byte == MINUS_CHAR);
                  word_used = 1'b1;
               end else begin
                  word.op   = OP_WEIGHT;
                  word.bad  = !is_digit;
                  word_used = 1'b1;
               end
            end
            default: begin
               word.bad = !is_digit && !is_space;
               if (pos_ff == 5'd1) begin
                  word.op   = OP_CODE;
                  word_used = 1'b1;
               end else if (pos_ff == 5'd2) begin
                  word.op   = OP_SIGN_B;
                  word.flag = rx_byte[1];
                  word_used = 1'b1;
               end else if (pos_ff >= 5'd4 && pos_ff <= 5'd9) begin
                  word.op   = OP_WEIGHT;
                  word_used = 1'b1;
               end else if (pos_ff >= 5'd10) begin
                  word.op   = OP_TARE;
                  word_used = 1'b1;
               end
            end
         endcase
      end
   end

   assign push      = byte_take && word_used;
   assign push_word = word;

   // frame position
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (byte_take) begin
         pos_ff <= pos_in;
      end
   end

endmodule

### rtl/sifp_queue.sv
// Two-word queue between the front classifier and the back end.
// Depends on sifp_pkg for the word type.
`timescale 1ns / 1ps

module sifp_queue
   import sifp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  entry_type      push_word,
   input  logic           pop,
   output entry_type      pop_word,
   output queue_stat_type stat
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign stat.full      = (count_ff == 2'd2);
   assign stat.not_empty = (count_ff != 2'd0);
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign pop_word       = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### rtl/sifp_back.sv
// Back end: accumulates digit fields and builds one result word per frame.
// Depends on sifp_pkg; takes words from sifp_queue, drives the result register.
`timescale 1ns / 1ps

module sifp_back
   import sifp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         word_valid,
   input  entry_type                    word,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [WEIGHT_WIDTH-1:0]      rsp_weight_digits,
   output logic [TARE_WIDTH-1:0]        rsp_tare_digits,
   output logic signed [EXP_WIDTH-1:0]  rsp_decimal_exponent,
   output logic                         rsp_value_negative,
   output logic                         rsp_sign_flag
);

   logic [WEIGHT_WIDTH-1:0] wacc_ff, wacc_in;
   logic [TARE_WIDTH-1:0]   tacc_ff, tacc_in;
   logic [3:0]              dcode_ff, dcode_in;
   logic                    minus_ff, minus_in;
   logic                    held_ff, held_in;
   logic                    fault_ff, fault_in;

   logic                    out_valid_ff, out_valid_in;
   logic [1:0]              out_status_ff, out_status_in;
   logic [WEIGHT_WIDTH-1:0] out_weight_ff, out_weight_in;
   logic [TARE_WIDTH-1:0]   out_tare_ff, out_tare_in;
   logic [EXP_WIDTH-1:0]    out_exp_ff, out_exp_in;
   logic                    out_neg_ff, out_neg_in;

   logic                    out_free;
   logic                    is_term;
   logic                    finish;
   logic [1:0]              status;

   // a terminator waits until the result register can take it
   assign out_free = !out_valid_ff || rsp_ready;
   assign is_term  = (word.op == OP_TERM);
   assign pop      = word_valid && (!is_term || out_free);
   assign finish   = pop && is_term;
   assign status   = word.flag ? ST_BAD_TERM : (fault_ff ? ST_NONDIGIT : ST_OK);

   // frame state update
   always_comb begin
      wacc_in  = wacc_ff;
      tacc_in  = tacc_ff;
      dcode_in = dcode_ff;
      minus_in = minus_ff;
      held_in  = held_ff;
      fault_in = fault_ff;
      if (pop) begin
         case (word.op)
            OP_START: begin
               wacc_in  = '0;
               tacc_in  = '0;
               dcode_in = '0;
               minus_in = 1'b0;
               fault_in = 1'b0;
            end
            OP_CODE:   dcode_in = {1'b0, word.low3};
            OP_SIGN_B: minus_in = word.flag;
            OP_WEIGHT: begin
               // times ten is two shifted copies
               wacc_in = (wacc_ff << 3) + (wacc_ff << 1)
                         + {{(WEIGHT_WIDTH-4){1'b0}}, word.digit};
               if (word.bad) begin
                  fault_in = 1'b1;
               end
            end
            OP_TARE: begin
               tacc_in = (tacc_ff << 3) + (tacc_ff << 1)
                         + {{(TARE_WIDTH-4){1'b0}}, word.digit};
               if (word.bad) begin
                  fault_in = 1'b1;
               end
            end
            OP_SIGN: begin
               minus_in = word.flag;
               if (word.fmt == FMT_DECIMAL) begin
                  tacc_in = {{(TARE_WIDTH-1){1'b0}}, word.aux};
               end
            end
            OP_DECIMAL: begin
               dcode_in = word.digit;
               if (word.bad) begin
                  fault_in = 1'b1;
               end
            end
            OP_TERM: begin
               if (status == ST_OK) begin
                  if (word.fmt == FMT_STATUS) begin
                     held_in = minus_ff;
                  end else if (word.fmt == FMT_DECIMAL) begin
                     held_in = minus_ff | tacc_ff[0];
                  end
               end
            end
            default: begin
               wacc_in = wacc_ff;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      out_valid_in  = finish || (out_valid_ff && !rsp_ready);
      out_status_in = out_status_ff;
      out_weight_in = out_weight_ff;
      out_tare_in   = out_tare_ff;
      out_exp_in    = out_exp_ff;
      out_neg_in    = out_neg_ff;
      if (finish) begin
         out_status_in = status;
         out_weight_in = '0;
         out_tare_in   = '0;
         out_exp_in    = '0;
         out_neg_in    = 1'b0;
         if (status == ST_OK) begin
            out_weight_in = wacc_ff;
            case (word.fmt)
               FMT_STATUS: begin
                  out_tare_in = tacc_ff;
                  out_exp_in  = 5'd1 - {1'b0, dcode_ff};
               end
               FMT_DECIMAL: begin
                  out_exp_in = 5'd0 - {1'b0, dcode_ff};
                  out_neg_in = minus_ff;
               end
               default: out_neg_in = minus_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wacc_ff      <= '0;
         tacc_ff      <= '0;
         dcode_ff     <= '0;
         minus_ff     <= 1'b0;
         held_ff      <= 1'b0;
         fault_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wacc_ff      <= wacc_in;
         tacc_ff      <= tacc_in;
         dcode_ff     <= dcode_in;
         minus_ff     <= minus_in;
         held_ff      <= held_in;
         fault_ff     <= fault_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_weight_ff <= out_weight_in;
      out_tare_ff   <= out_tare_in;
      out_exp_ff    <= out_exp_in;
      out_neg_ff    <= out_neg_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_weight_digits    = out_weight_ff;
   assign rsp_tare_digits      = out_tare_ff;
   assign rsp_decimal_exponent = $signed(out_exp_ff);
   assign rsp_value_negative   = out_neg_ff;
   assign rsp_sign_flag        = held_ff;

endmodule

### rtl/scale_indicator_frame_parser.sv
// Top level of the weighing indicator frame parser: CSR, front, queue, back.
// Depends on sifp_pkg, sifp_front, sifp_queue, sifp_back and the defines header.
//
//   channel | ports  | dir | carries
//   --------+--------+-----+-------------------------------------------
//   input   | req_*  | in  | one received byte per word
//   result  | rsp_*  | out | one parsed frame per word
//   config  | csr_*  | in  | frame_format register at byte address 0
//
// One byte is taken every cycle while the queue has room; the front classifier
// and the accumulate step of the back end both run at one word per clock,
// save while a terminator waits for the result register; a terminator byte is
// queued, and its result is registered once the words ahead of it are taken.
// Reset (synchronous) clears the format to 0 and puts the parser in hunting.
// A stalled result holds the back end at the terminator word; the two-word
// queue then fills and req_ready drops only when it is full.
`timescale 1ns / 1ps
`include "scale_indicator_frame_parser_defines.svh"

module scale_indicator_frame_parser
   import sifp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [WEIGHT_WIDTH-1:0]     rsp_weight_digits,
   output logic [TARE_WIDTH-1:0]       rsp_tare_digits,
   output logic signed [EXP_WIDTH-1:0] rsp_decimal_exponent,
   output logic                        rsp_value_negative,
   output logic                        rsp_sign_flag,
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic [1:0]     fmt_ff, fmt_in;
   logic           csr_write;
   logic           byte_take;
   logic           push;
   entry_type      push_word;
   logic           pop;
   entry_type      pop_word;
   queue_stat_type q_stat;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign fmt_in     = (csr_write && (csr_paddr[2] == CSR_IDX_FORMAT)) ?
                       csr_pwdata[1:0] : fmt_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_FORMAT) ? {30'd0, fmt_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_STATUS;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   // input handshake
   assign req_ready = !q_stat.full;
   assign byte_take = req_valid && req_ready;

   sifp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .frame_format (fmt_ff),
      .byte_take    (byte_take),
      .rx_byte      (req_rx_byte),
      .push         (push),
      .push_word    (push_word)
   );

   sifp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .stat      (q_stat)
   );

   sifp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .word_valid           (q_stat.not_empty),
      .word                 (pop_word),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_weight_digits    (rsp_weight_digits),
      .rsp_tare_digits      (rsp_tare_digits),
      .rsp_decimal_exponent (rsp_decimal_exponent),
      .rsp_value_negative   (rsp_value_negative),
      .rsp_sign_flag        (rsp_sign_flag)
   );

   // checks
   `SIFP_ASSERT(a_no_overflow, !(push && q_stat.full), "queue overflow")
   `SIFP_ASSERT(a_status_code, rsp_valid |-> (rsp_status != 2'd3), "bad status code")
   `SIFP_ASSERT(a_fault_zero, (rsp_valid && rsp_status != ST_OK) |-> (rsp_weight_digits == '0 && rsp_tare_digits == '0 && rsp_decimal_exponent == '0 && !rsp_value_negative), "faulty frame carries data")
   `SIFP_ASSERT(a_exp_range, rsp_valid |-> (rsp_decimal_exponent >= -5'sd9 && rsp_decimal_exponent <= 5'sd1), "exponent out of range")
   `SIFP_ASSERT_ALWAYS(a_pop_needs_word, pop |-> q_stat.not_empty, "pop from empty queue")

endmodule
